// ----- rtl/etpq_pkg.sv -----
// Shared types and codes for the event time priority queue.
// No dependencies; used by event_time_priority_queue.
package etpq_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_PAST      = 3'd4
  } status_e;

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_SU_RD   = 10'b00_0000_0010,
    S_SU_CMP  = 10'b00_0000_0100,
    S_POP_LD  = 10'b00_0000_1000,
    S_RM_SCAN = 10'b00_0001_0000,
    S_RM_END  = 10'b00_0010_0000,
    S_DEL_LD  = 10'b00_0100_0000,
    S_SD_RD   = 10'b00_1000_0000,
    S_SD_C1   = 10'b01_0000_0000,
    S_SD_C2   = 10'b10_0000_0000
  } state_e;

endpackage

// ----- rtl/event_time_priority_queue.sv -----
// Event time priority queue: binary min-heap in an on-chip memory, sequenced.
// Depends on etpq_pkg (op, status and state codes).

// Discrete-event scheduler queue. A request is taken when start is high and busy
// is low; its one result appears on the result ports for exactly one cycle with
// done_o high, and the receiver cannot stall it. Insert, pop and remove by id
// work on a binary min-heap ordered by (time, id), so equal times pop with the
// lower id first. An accepted request steps through a sequencer paced by the
// single heap memory (one write port, two registered read ports) and one shared
// key comparator. Insert climbs, reading and comparing one parent per level;
// pop loads the root and the last entry, then descends, reading both children,
// picking the smaller and comparing it with the moved entry per level (a lone
// entry just pops); remove scans every entry for the id, then fetches the last
// entry, which climbs or else descends. done_o rises in the cycle after the
// last busy cycle. Rejected inserts, unused op codes and pops of an empty queue
// keep busy low and answer in the next cycle. With DEPTH 64 a heap has at most
// 6 levels below the root. There is no clearing pass after reset; the queue is
// usable as soon as reset is released.
module event_time_priority_queue #(
  parameter int DEPTH      = 64,
  parameter int TIME_WIDTH = 32,
  parameter int ID_WIDTH   = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      op_i,
  input  logic [ID_WIDTH-1:0]             event_id_i,
  input  logic [TIME_WIDTH-1:0]           event_time_i,
  output logic                            done_o,
  output logic [2:0]                      status_o,
  output logic [ID_WIDTH-1:0]             out_id_o,
  output logic [TIME_WIDTH-1:0]           out_time_o,
  output logic [$clog2(DEPTH+1)-1:0]      entry_total_o,
  output logic [TIME_WIDTH-1:0]           current_time_o
);

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CHILD_W = IDX_W + 2;  // 2k+2 for k up to DEPTH-1
  localparam int KEY_W   = TIME_WIDTH + ID_WIDTH;

  // Heap storage: key = {time, id}, so a plain unsigned compare is the order.
  logic [KEY_W-1:0] mem [DEPTH];

  etpq_pkg::state_e  state_q, state_d;
  etpq_pkg::status_e status_q, status_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [TIME_WIDTH-1:0] now_q, now_d;
  logic [ID_WIDTH-1:0]   out_id_q, out_id_d;
  logic [TIME_WIDTH-1:0] out_time_q, out_time_d;

  // Working registers of the sequencer.
  logic [KEY_W-1:0]  x_q, x_d;            // element being sifted (the hole's owner)
  logic [IDX_W-1:0]  k_q, k_d;            // hole position
  logic              del_q, del_d;        // sift after a delete (may go down)
  logic              moved_q, moved_d;    // sift-up moved at least one level
  logic [KEY_W-1:0]  child_key_q, child_key_d;
  logic [IDX_W-1:0]  child_idx_q, child_idx_d;
  logic              rvalid_q, rvalid_d;  // right child exists
  logic [ID_WIDTH-1:0] tgt_id_q, tgt_id_d;
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic              chk_v_q, chk_v_d;
  logic [IDX_W-1:0]  chk_idx_q, chk_idx_d;
  logic              hit_q, hit_d;
  logic [IDX_W-1:0]  found_q, found_d;
  logic [KEY_W-1:0]  found_key_q, found_key_d;

  // Memory ports.
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa, rd_addr_a, rd_addr_b;
  logic [KEY_W-1:0]  mem_wd, rd_a_q, rd_b_q;

  // Shared comparator.
  logic [KEY_W-1:0]  cmp_a, cmp_b;
  logic              cmp_lt;

  // Index arithmetic.
  logic [IDX_W-1:0]   parent_idx, last_idx;
  logic [CHILD_W-1:0] left_idx, right_idx, cnt_ext;

  logic              fin, su_halt;
  etpq_pkg::status_e fin_status;

  assign parent_idx = (k_q - IDX_W'(1)) >> 1;
  assign last_idx   = IDX_W'(count_q - CNT_W'(1));
  assign left_idx   = CHILD_W'({k_q, 1'b1});
  assign right_idx  = left_idx + CHILD_W'(1);
  assign cnt_ext    = CHILD_W'(count_q);

  // Operand select for the one comparator.
  always_comb begin
    unique case (state_q)
      etpq_pkg::S_IDLE: begin
        cmp_a = {event_time_i, {ID_WIDTH{1'b0}}};
        cmp_b = {now_q, {ID_WIDTH{1'b0}}};
      end
      etpq_pkg::S_RM_SCAN: begin
        cmp_a = rd_a_q;        // ids match, so this is a time compare
        cmp_b = found_key_q;
      end
      etpq_pkg::S_SD_C1: begin
        cmp_a = rd_b_q;        // right child vs left child
        cmp_b = rd_a_q;
      end
      etpq_pkg::S_SD_C2: begin
        cmp_a = child_key_q;
        cmp_b = x_q;
      end
      default: begin           // sift-up: element vs parent
        cmp_a = x_q;
        cmp_b = rd_a_q;
      end
    endcase
  end

  assign cmp_lt = cmp_a < cmp_b;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    done_d      = 1'b0;
    count_d     = count_q;
    now_d       = now_q;
    out_id_d    = out_id_q;
    out_time_d  = out_time_q;
    x_d         = x_q;
    k_d         = k_q;
    del_d       = del_q;
    moved_d     = moved_q;
    child_key_d = child_key_q;
    child_idx_d = child_idx_q;
    rvalid_d    = rvalid_q;
    tgt_id_d    = tgt_id_q;
    scan_d      = scan_q;
    chk_v_d     = chk_v_q;
    chk_idx_d   = chk_idx_q;
    hit_d       = hit_q;
    found_d     = found_q;
    found_key_d = found_key_q;
    mem_we      = 1'b0;
    mem_wa      = k_q;
    mem_wd      = x_q;
    rd_addr_a   = '0;
    rd_addr_b   = '0;
    fin         = 1'b0;
    fin_status  = etpq_pkg::ST_OK;
    su_halt     = 1'b0;

    unique case (state_q)
      etpq_pkg::S_IDLE: begin
        if (start) begin
          out_id_d   = '0;
          out_time_d = '0;
          unique case (op_i)
            etpq_pkg::OP_INSERT: begin
              if (count_q == CNT_W'(DEPTH)) begin
                fin        = 1'b1;
                fin_status = etpq_pkg::ST_FULL;
              end else if (cmp_lt) begin
                fin        = 1'b1;
                fin_status = etpq_pkg::ST_PAST;
              end else begin
                x_d     = {event_time_i, event_id_i};
                k_d     = count_q[IDX_W-1:0];
                count_d = count_q + CNT_W'(1);
                del_d   = 1'b0;
                moved_d = 1'b0;
                state_d = etpq_pkg::S_SU_RD;
              end
            end
            etpq_pkg::OP_POP: begin
              if (count_q == '0) begin
                fin        = 1'b1;
                fin_status = etpq_pkg::ST_EMPTY;
              end else begin
                rd_addr_a = '0;
                rd_addr_b = last_idx;
                state_d   = etpq_pkg::S_POP_LD;
              end
            end
            etpq_pkg::OP_REMOVE: begin
              tgt_id_d = event_id_i;
              scan_d   = '0;
              chk_v_d  = 1'b0;
              hit_d    = 1'b0;
              state_d  = etpq_pkg::S_RM_SCAN;
            end
            default: begin
              fin = 1'b1;      // unused code: no change
            end
          endcase
        end
      end

      etpq_pkg::S_SU_RD: begin
        if (k_q == '0) begin
          su_halt = 1'b1;
        end else begin
          rd_addr_a = parent_idx;
          state_d   = etpq_pkg::S_SU_CMP;
        end
      end

      etpq_pkg::S_SU_CMP: begin
        if (cmp_lt) begin
          mem_we  = 1'b1;
          mem_wd  = rd_a_q;    // parent drops into the hole
          k_d     = parent_idx;
          moved_d = 1'b1;
          state_d = etpq_pkg::S_SU_RD;
        end else begin
          su_halt = 1'b1;
        end
      end

      etpq_pkg::S_POP_LD: begin
        out_id_d   = rd_a_q[ID_WIDTH-1:0];
        out_time_d = rd_a_q[KEY_W-1:ID_WIDTH];
        now_d      = rd_a_q[KEY_W-1:ID_WIDTH];
        count_d    = count_q - CNT_W'(1);
        x_d        = rd_b_q;
        k_d        = '0;
        del_d      = 1'b1;
        moved_d    = 1'b0;
        if (count_q == CNT_W'(1)) begin
          fin = 1'b1;
        end else begin
          state_d = etpq_pkg::S_SD_RD;
        end
      end

      etpq_pkg::S_RM_SCAN: begin
        // Read one entry a cycle; check the one read last cycle.
        if (scan_q < count_q) begin
          rd_addr_a = scan_q[IDX_W-1:0];
          scan_d    = scan_q + CNT_W'(1);
          chk_v_d   = 1'b1;
          chk_idx_d = scan_q[IDX_W-1:0];
        end else begin
          chk_v_d = 1'b0;
        end
        if (chk_v_q && (rd_a_q[ID_WIDTH-1:0] == tgt_id_q) && (!hit_q || cmp_lt)) begin
          hit_d       = 1'b1;
          found_d     = chk_idx_q;
          found_key_d = rd_a_q;
        end
        if ((scan_q >= count_q) && !chk_v_q) begin
          state_d = etpq_pkg::S_RM_END;
        end
      end

      etpq_pkg::S_RM_END: begin
        if (!hit_q) begin
          fin        = 1'b1;
          fin_status = etpq_pkg::ST_NOT_FOUND;
        end else begin
          count_d = count_q - CNT_W'(1);
          k_d     = found_q;
          del_d   = 1'b1;
          moved_d = 1'b0;
          if (found_q == last_idx) begin
            fin = 1'b1;        // last slot: just shrink
          end else begin
            rd_addr_a = last_idx;
            state_d   = etpq_pkg::S_DEL_LD;
          end
        end
      end

      etpq_pkg::S_DEL_LD: begin
        x_d     = rd_a_q;
        state_d = etpq_pkg::S_SU_RD;
      end

      etpq_pkg::S_SD_RD: begin
        if (left_idx >= cnt_ext) begin
          mem_we = 1'b1;       // leaf: x settles here
          fin    = 1'b1;
        end else begin
          rd_addr_a = left_idx[IDX_W-1:0];
          rd_addr_b = right_idx[IDX_W-1:0];
          rvalid_d  = right_idx < cnt_ext;
          state_d   = etpq_pkg::S_SD_C1;
        end
      end

      etpq_pkg::S_SD_C1: begin
        if (rvalid_q && cmp_lt) begin
          child_key_d = rd_b_q;
          child_idx_d = right_idx[IDX_W-1:0];
        end else begin
          child_key_d = rd_a_q;
          child_idx_d = left_idx[IDX_W-1:0];
        end
        state_d = etpq_pkg::S_SD_C2;
      end

      etpq_pkg::S_SD_C2: begin
        mem_we = 1'b1;
        if (cmp_lt) begin
          mem_wd  = child_key_q;  // smaller child rises into the hole
          k_d     = child_idx_q;
          state_d = etpq_pkg::S_SD_RD;
        end else begin
          fin = 1'b1;
        end
      end

      default: begin
        state_d = etpq_pkg::S_IDLE;
      end
    endcase

    // Sift-up stopped: a delete that did not climb continues downward.
    if (su_halt) begin
      if (del_q && !moved_q) begin
        state_d = etpq_pkg::S_SD_RD;
      end else begin
        mem_we = 1'b1;
        fin    = 1'b1;
      end
    end

    if (fin) begin
      done_d   = 1'b1;
      status_d = fin_status;
      state_d  = etpq_pkg::S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= etpq_pkg::S_IDLE;
      done_q  <= 1'b0;
      count_q <= '0;
      now_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      count_q <= count_d;
      now_q   <= now_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    out_id_q    <= out_id_d;
    out_time_q  <= out_time_d;
    x_q         <= x_d;
    k_q         <= k_d;
    del_q       <= del_d;
    moved_q     <= moved_d;
    child_key_q <= child_key_d;
    child_idx_q <= child_idx_d;
    rvalid_q    <= rvalid_d;
    tgt_id_q    <= tgt_id_d;
    scan_q      <= scan_d;
    chk_v_q     <= chk_v_d;
    chk_idx_q   <= chk_idx_d;
    hit_q       <= hit_d;
    found_q     <= found_d;
    found_key_q <= found_key_d;
  end

  // Heap memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_a_q <= mem[rd_addr_a];
    rd_b_q <= mem[rd_addr_b];
  end

  assign busy           = state_q != etpq_pkg::S_IDLE;
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_id_o       = out_id_q;
  assign out_time_o     = out_time_q;
  assign entry_total_o  = count_q;
  assign current_time_o = now_q;

  // Fill level stays within the heap.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // Each request changes the fill level by at most one.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ((count_q == $past(count_q) + CNT_W'(1)) || (count_q == $past(count_q) - CNT_W'(1))))
    else $error("entry count jumped");

  // Simulation time never runs backward.
  a_time_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    now_q >= $past(now_q))
    else $error("current time decreased");

  // The hole being sifted always lies inside the live heap.
  a_hole_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == etpq_pkg::S_SU_CMP) || (state_q == etpq_pkg::S_SD_C2)) |->
      (CNT_W'(k_q) < count_q))
    else $error("sift position outside heap");

  // A full report only when the heap really is full.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q == etpq_pkg::ST_FULL)) |-> (count_q == CNT_W'(DEPTH)))
    else $error("full reported while not full");

endmodule

// ----- verif/event_time_priority_queue_tb.sv -----
// Self-checking testbench for event_time_priority_queue: directed and random requests,
// with each result checked against a behavioral min-heap scheduler model.
// Depends on etpq_pkg and event_time_priority_queue from rtl/.
module event_time_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 64;
  localparam int TIME_WIDTH = 32;
  localparam int ID_WIDTH   = 16;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // The 2-bit op field has one code with no operation behind it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 630;   // counted random requests (unused op excluded)
  localparam int PHASE_LEN    = 90;    // requests per fill / drain / mixed phase
  localparam int QUIET_TAIL   = 60;    // no sender gaps for the last requests
  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake and no result
  localparam int DRAIN_CYCLES = 100;   // settle time after the last result

  typedef struct packed {
    logic [1:0]            op;
    logic [ID_WIDTH-1:0]   id;
    logic [TIME_WIDTH-1:0] tm;
  } request_t;

  typedef struct packed {
    etpq_pkg::status_e     status;
    logic [ID_WIDTH-1:0]   id;
    logic [TIME_WIDTH-1:0] tm;
    logic [CNT_W-1:0]      total;
    logic [TIME_WIDTH-1:0] now;
  } outcome_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  start        = 1'b0;
  logic [1:0]            req_op       = etpq_pkg::OP_INSERT;
  logic [ID_WIDTH-1:0]   req_id       = '0;
  logic [TIME_WIDTH-1:0] req_time     = '0;
  logic                  busy;
  logic                  done_o;
  logic [2:0]            status_o;
  logic [ID_WIDTH-1:0]   out_id_o;
  logic [TIME_WIDTH-1:0] out_time_o;
  logic [CNT_W-1:0]      entry_total_o;
  logic [TIME_WIDTH-1:0] current_time_o;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  event_time_priority_queue #(
    .DEPTH      (DEPTH),
    .TIME_WIDTH (TIME_WIDTH),
    .ID_WIDTH   (ID_WIDTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (req_op),
    .event_id_i     (req_id),
    .event_time_i   (req_time),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_id_o       (out_id_o),
    .out_time_o     (out_time_o),
    .entry_total_o  (entry_total_o),
    .current_time_o (current_time_o)
  );

  // ---------------------------------------------------------------------------
  // Scheduler model: heap of (time, id) pairs plus the simulation clock.
  // Only slots below sched_count are ever read.
  // ---------------------------------------------------------------------------
  logic [TIME_WIDTH-1:0] sched_time [DEPTH];
  logic [ID_WIDTH-1:0]   sched_id   [DEPTH];
  int unsigned           sched_count = 0;
  logic [TIME_WIDTH-1:0] sched_now   = '0;

  // Heap order: earlier time first, lower id on a tie.
  function automatic bit runs_first(int unsigned a, int unsigned b);
    if (sched_time[a] != sched_time[b]) return sched_time[a] < sched_time[b];
    return sched_id[a] < sched_id[b];
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [TIME_WIDTH-1:0] t;
    logic [ID_WIDTH-1:0]   i;
    t = sched_time[a];
    i = sched_id[a];
    sched_time[a] = sched_time[b];
    sched_id[a]   = sched_id[b];
    sched_time[b] = t;
    sched_id[b]   = i;
  endfunction

  function automatic void raise_slot(int unsigned k);
    int unsigned parent;
    while (k > 0) begin
      parent = (k - 1) / 2;
      if (!runs_first(k, parent)) break;
      swap_slots(k, parent);
      k = parent;
    end
  endfunction

  function automatic void lower_slot(int unsigned k);
    int unsigned left, right, best;
    forever begin
      left  = 2 * k + 1;
      right = left + 1;
      best  = k;
      if (left < sched_count && runs_first(left, best)) best = left;
      if (right < sched_count && runs_first(right, best)) best = right;
      if (best == k) break;
      swap_slots(k, best);
      k = best;
    end
  endfunction

  // Fill slot k from the last entry, then restore order both ways.
  function automatic void drop_slot(int unsigned k);
    sched_count--;
    if (k != sched_count) begin
      sched_time[k] = sched_time[sched_count];
      sched_id[k]   = sched_id[sched_count];
      raise_slot(k);
      lower_slot(k);
    end
  endfunction

  function automatic outcome_t schedule_request(request_t rq);
    outcome_t    res;
    int unsigned found;
    bit          hit;
    res.status = etpq_pkg::ST_OK;
    res.id     = '0;
    res.tm     = '0;
    found      = 0;
    hit        = 1'b0;
    case (rq.op)
      etpq_pkg::OP_INSERT: begin
        // Fullness wins over a time in the past.
        if (sched_count >= DEPTH) begin
          res.status = etpq_pkg::ST_FULL;
        end else if (rq.tm < sched_now) begin
          res.status = etpq_pkg::ST_PAST;
        end else begin
          sched_time[sched_count] = rq.tm;
          sched_id[sched_count]   = rq.id;
          sched_count++;
          raise_slot(sched_count - 1);
        end
      end
      etpq_pkg::OP_POP: begin
        if (sched_count == 0) begin
          res.status = etpq_pkg::ST_EMPTY;
        end else begin
          res.id    = sched_id[0];
          res.tm    = sched_time[0];
          sched_now = sched_time[0];
          drop_slot(0);
        end
      end
      etpq_pkg::OP_REMOVE: begin
        // Duplicate ids: the copy with the earliest time goes.
        for (int unsigned k = 0; k < sched_count; k++) begin
          if (sched_id[k] == rq.id && (!hit || sched_time[k] < sched_time[found])) begin
            found = k;
            hit   = 1'b1;
          end
        end
        if (hit) drop_slot(found);
        else res.status = etpq_pkg::ST_NOT_FOUND;
      end
      default: ;  // unused code: nothing changes, status ok
    endcase
    res.total = sched_count[CNT_W-1:0];
    res.now   = sched_now;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request stream and result bookkeeping
  // ---------------------------------------------------------------------------
  request_t    pending_requests [$];
  outcome_t    expected_results [$];
  logic        req_taken      = 1'b0;  // request handshake at the last rising edge
  int unsigned mismatch_count = 0;
  int unsigned result_no      = 0;
  int unsigned stall_cycles   = 0;

  task automatic note_mismatch(input string field, input logic [31:0] seen,
                               input logic [31:0] want);
    mismatch_count++;
    $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
             $realtime, result_no, field, seen, want);
  endtask

  task automatic queue_request(input logic [1:0] op, input logic [ID_WIDTH-1:0] id,
                               input logic [TIME_WIDTH-1:0] tm);
    request_t rq;
    rq.op = op;
    rq.id = id;
    rq.tm = tm;
    pending_requests = {pending_requests, rq};
  endtask

  // Driver: inputs move on the falling edge. A request stays up until busy lets
  // it through; between requests the sender may pause for a short burst.
  int unsigned sender_gap = 0;

  always @(negedge clk_i) begin : drive_requests
    request_t nxt;
    if (rst_ni && (!start || req_taken)) begin
      if (sender_gap != 0) begin
        sender_gap--;
        start <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        nxt = pending_requests.pop_front();
        req_op   <= nxt.op;
        req_id   <= nxt.id;
        req_time <= nxt.tm;
        start    <= 1'b1;
        if (pending_requests.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
          sender_gap = $urandom_range(1, 6);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: on the rising edge, check the result that ends this cycle, then
  // predict for a request taken at this edge. Check first, so a result and a new
  // request on the same edge never meet out of order.
  always @(posedge clk_i) begin : check_results
    outcome_t want;
    request_t taken;
    if (rst_ni) begin
      if (done_o) begin
        result_no++;
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected result, status", 32'(status_o), '0);
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status)
            note_mismatch("status", 32'(status_o), 32'(want.status));
          if (out_id_o !== want.id)
            note_mismatch("out_id", 32'(out_id_o), 32'(want.id));
          if (out_time_o !== want.tm)
            note_mismatch("out_time", out_time_o, want.tm);
          if (entry_total_o !== want.total)
            note_mismatch("entry_total", 32'(entry_total_o), 32'(want.total));
          if (current_time_o !== want.now)
            note_mismatch("current_time", current_time_o, want.now);
        end
      end
      if (start && !busy) begin
        taken.op = req_op;
        taken.id = req_id;
        taken.tm = req_time;
        expected_results = {expected_results, schedule_request(taken)};
      end
    end
    req_taken <= rst_ni && start && !busy;
  end

  // Watchdog: no request and no result for too long means the block hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("event_time_priority_queue test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of test
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [ID_WIDTH-1:0]   live_ids [$];
    logic [TIME_WIDTH-1:0] base;
    logic [ID_WIDTH-1:0]   id;
    int                    counted, blk, cur_blk, roll, phase;

    // Directed: empty pop, absent id, unused code, field extremes, time ties,
    // duplicate ids, past and equal-to-now inserts.
    queue_request(etpq_pkg::OP_POP,    16'h0000, 32'h0000_0000);
    queue_request(etpq_pkg::OP_REMOVE, 16'h0005, 32'h0000_0000);
    queue_request(OP_UNUSED,           16'hFFFF, 32'hFFFF_FFFF);
    queue_request(etpq_pkg::OP_INSERT, 16'h0000, 32'h0000_0000);  // time equal to now
    queue_request(etpq_pkg::OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    queue_request(etpq_pkg::OP_INSERT, 16'h0007, 32'd100);
    queue_request(etpq_pkg::OP_INSERT, 16'h0003, 32'd100);        // tie with id 7
    queue_request(etpq_pkg::OP_INSERT, 16'h0007, 32'd50);         // duplicate id, earlier
    queue_request(etpq_pkg::OP_REMOVE, 16'h0007, 32'h0000_0000);  // takes the time-50 copy
    queue_request(etpq_pkg::OP_REMOVE, 16'hFFFF, 32'h0000_0000);
    queue_request(etpq_pkg::OP_INSERT, 16'h5555, 32'hAAAA_AAAA);
    queue_request(etpq_pkg::OP_REMOVE, 16'h5555, 32'h5555_5555);
    queue_request(etpq_pkg::OP_POP,    16'hAAAA, 32'h5555_5555);  // id 0 at time 0
    queue_request(etpq_pkg::OP_POP,    16'h0000, 32'h0000_0000);  // id 3 beats id 7
    queue_request(etpq_pkg::OP_INSERT, 16'h0009, 32'd99);         // in the past
    queue_request(etpq_pkg::OP_INSERT, 16'h0009, 32'd100);        // equal to now
    queue_request(etpq_pkg::OP_POP,    16'h0000, 32'h0000_0000);
    queue_request(etpq_pkg::OP_POP,    16'h0000, 32'h0000_0000);
    queue_request(etpq_pkg::OP_POP,    16'h0000, 32'h0000_0000);  // empty again
    queue_request(etpq_pkg::OP_REMOVE, 16'h0009, 32'h0000_0000);

    // Random: phases of fill, drain and mixed traffic so the heap runs from
    // empty to full and back. Insert times track a slowly rising base so most
    // are in the future; a few are pulled below it on purpose.
    base    = 32'd200;
    counted = 0;
    cur_blk = 0;
    while (counted < RANDOM_ITEMS) begin
      blk = counted / PHASE_LEN;
      if (blk != cur_blk) begin
        cur_blk = blk;
        base += $urandom_range(0, 1 << 27);
      end
      phase = blk % 3;
      if ($urandom_range(0, 49) == 0) begin
        queue_request(OP_UNUSED, ID_WIDTH'($urandom_range(0, 16'hFFFF)), $urandom);
        continue;
      end
      roll = $urandom_range(0, 99);
      if ((phase == 0 && roll < 90) || (phase == 1 && roll < 15) ||
          (phase == 2 && roll < 50)) begin
        id = ($urandom_range(0, 3) == 0) ? ID_WIDTH'($urandom_range(0, 16'hFFFF))
                                         : ID_WIDTH'($urandom_range(0, 31));
        if ($urandom_range(0, 9) == 0)
          queue_request(etpq_pkg::OP_INSERT, id, $urandom_range(0, base));
        else
          queue_request(etpq_pkg::OP_INSERT, id, base + $urandom_range(0, 255));
        live_ids = {live_ids, id};
        if (live_ids.size() > 80) void'(live_ids.pop_front());
      end else if ((phase == 0 && roll < 95) || (phase == 1 && roll < 85) ||
                   (phase == 2 && roll < 75)) begin
        queue_request(etpq_pkg::OP_POP, ID_WIDTH'($urandom_range(0, 16'hFFFF)), $urandom);
      end else begin
        if (live_ids.size() != 0 && $urandom_range(0, 4) != 0)
          id = live_ids[$urandom_range(0, live_ids.size() - 1)];
        else
          id = ID_WIDTH'($urandom_range(0, 16'hFFFF));
        queue_request(etpq_pkg::OP_REMOVE, id, $urandom);
      end
      base += $urandom_range(0, 6);
      counted++;
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    #1 rst_ni = 1'b1;

    // All requests sent and every result back, then let the block settle.
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || start || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("event_time_priority_queue test passed");
    end else begin
      $display("event_time_priority_queue test failed");
    end
    $finish;
  end

endmodule

// ----- event_time_priority_queue.f -----
rtl/etpq_pkg.sv
rtl/event_time_priority_queue.sv
verif/event_time_priority_queue_tb.sv
